// ----- hw/rtl/vcap_pkg.sv -----
// ============================================================================
// vcap_pkg
// Shared types and constants for the voice channel allocator with pan.
// ============================================================================
package vcap_pkg;

    // Reserved (pinned) channels 0..2; shared channels follow
    localparam int RESERVED_COUNT = 3;

    // Pan gain arithmetic
    localparam int FULL_SCALE = 16'hffff;
    localparam int PAN_SPAN   = 8'hff;
    localparam int GAIN_SHIFT = 12;
    localparam int GAIN_W     = 8;
    localparam int VOL_W      = 4;
    localparam int MAG_W      = 10;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int PROD_W     = 20;

    // Configuration port
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SAW_UP_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAW_IDLE_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAW_FULL_ID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAW_HIT_ID    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STONE_MOVE_ID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PISTOL_ID     = 3'd5;

    localparam logic [CFG_W-1:0] RST_SAW_UP_ID     = 8'd10;
    localparam logic [CFG_W-1:0] RST_SAW_IDLE_ID   = 8'd11;
    localparam logic [CFG_W-1:0] RST_SAW_FULL_ID   = 8'd12;
    localparam logic [CFG_W-1:0] RST_SAW_HIT_ID    = 8'd13;
    localparam logic [CFG_W-1:0] RST_STONE_MOVE_ID = 8'd22;
    localparam logic [CFG_W-1:0] RST_PISTOL_ID     = 8'd1;

    typedef struct packed {
        logic [7:0] sound_id;
        logic [3:0] volume;
        logic [8:0] separation;
        logic [7:0] busy_mask;
    } vcap_req_t;

    typedef struct packed {
        logic       granted;
        logic [2:0] channel;
        logic       stop_previous;
        logic [7:0] left_gain;
        logic [7:0] right_gain;
    } vcap_rsp_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;      // capture request beat
        logic classify;  // pinned lookup, squares
        logic probe;     // one round-robin probe
        logic scale;     // gain multiply
        logic emit;      // write response register
    } vcap_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic pinned;
        logic probe_free;
        logic out_free;
    } vcap_status_t;

endpackage

// ----- hw/rtl/vcap_ctrl.sv -----
// ============================================================================
// vcap_ctrl
// Sequencer: classify, round-robin scan over shared channels, gain, emit.
// ============================================================================
module vcap_ctrl #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  vcap_pkg::vcap_status_t status,
    output vcap_pkg::vcap_cmd_t   cmd
);
    import vcap_pkg::*;

    localparam int SHARED_COUNT = CHANNEL_COUNT - RESERVED_COUNT;
    localparam int CNT_W        = $clog2(SHARED_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SHARED_COUNT - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CLASSIFY = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_SCALE    = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                cnt_next     = '0;
                state_next   = status.pinned ? ST_SCALE : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.probe = 1'b1;
                if (status.probe_free || cnt_reg == CNT_LAST)
                    state_next = ST_SCALE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // scan never outlives the shared channel count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> cnt_reg <= CNT_LAST)
        else $error("scan counter past last shared channel");

    // pinned request skips the scan
    a_pinned_skip: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLASSIFY && status.pinned |=> state_reg == ST_SCALE)
        else $error("pinned request entered scan");

    // emit only when response register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("emit while response register full");

endmodule

// ----- hw/rtl/vcap_datapath.sv -----
// ============================================================================
// vcap_datapath
// Config registers, request hold, rotate pointer, pan gain math, response reg.
// ============================================================================
module vcap_datapath #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vcap_pkg::vcap_req_t              req,
    output vcap_pkg::vcap_rsp_t              rsp,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  logic                             cfg_we,
    input  logic [vcap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vcap_pkg::CFG_W-1:0]       cfg_data,
    input  vcap_pkg::vcap_cmd_t              cmd,
    output vcap_pkg::vcap_status_t           status
);
    import vcap_pkg::*;

    localparam int PTR_W  = $clog2(CHANNEL_COUNT);
    localparam int SLOT_W = (PTR_W > 3) ? PTR_W : 3;
    localparam logic [PTR_W-1:0] PTR_FIRST = PTR_W'(RESERVED_COUNT);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(CHANNEL_COUNT - 1);

    // config
    logic [CFG_W-1:0] saw_up_reg, saw_idle_reg, saw_full_reg, saw_hit_reg;
    logic [CFG_W-1:0] stone_reg, pistol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_up_reg   <= RST_SAW_UP_ID;
            saw_idle_reg <= RST_SAW_IDLE_ID;
            saw_full_reg <= RST_SAW_FULL_ID;
            saw_hit_reg  <= RST_SAW_HIT_ID;
            stone_reg    <= RST_STONE_MOVE_ID;
            pistol_reg   <= RST_PISTOL_ID;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAW_UP_ID:     saw_up_reg   <= cfg_data;
                CFG_SAW_IDLE_ID:   saw_idle_reg <= cfg_data;
                CFG_SAW_FULL_ID:   saw_full_reg <= cfg_data;
                CFG_SAW_HIT_ID:    saw_hit_reg  <= cfg_data;
                CFG_STONE_MOVE_ID: stone_reg    <= cfg_data;
                CFG_PISTOL_ID:     pistol_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // request hold
    vcap_req_t item_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= req;
    end

    // pinned lookup; pistol beats stone beats the saw group
    logic             pin_ch0, pin_ch1, pin_ch2;
    logic [PTR_W-1:0] pin_slot;

    assign pin_ch0 = (item_reg.sound_id == saw_up_reg)   ||
                     (item_reg.sound_id == saw_idle_reg) ||
                     (item_reg.sound_id == saw_full_reg) ||
                     (item_reg.sound_id == saw_hit_reg);
    assign pin_ch1 = item_reg.sound_id == stone_reg;
    assign pin_ch2 = item_reg.sound_id == pistol_reg;

    always_comb
    begin
        if (pin_ch2)
            pin_slot = PTR_W'(2);
        else if (pin_ch1)
            pin_slot = PTR_W'(1);
        else
            pin_slot = '0;
    end

    // round-robin probe; channels without a busy bit read as free
    logic [PTR_W-1:0]         ptr_reg;
    logic [PTR_W-1:0]         cand;
    logic [CHANNEL_COUNT-1:0] busy_ext;

    assign cand     = (ptr_reg == PTR_LAST) ? PTR_FIRST : ptr_reg + 1'b1;
    assign busy_ext = CHANNEL_COUNT'(item_reg.busy_mask);

    assign status.pinned     = pin_ch0 || pin_ch1 || pin_ch2;
    assign status.probe_free = !busy_ext[cand];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr_reg <= PTR_FIRST;
        else if (cmd.probe)
            ptr_reg <= cand;
    end

    // grant / slot
    logic             granted_reg, stop_reg;
    logic [PTR_W-1:0] slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            granted_reg <= 1'b0;
            stop_reg    <= 1'b0;
        end
        else if (cmd.classify)
        begin
            granted_reg <= status.pinned;
            stop_reg    <= status.pinned;
        end
        else if (cmd.probe && status.probe_free)
        begin
            granted_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.classify)
            slot_reg <= pin_slot;
        else if (cmd.probe && status.probe_free)
            slot_reg <= cand;
    end

    // pan distances as magnitudes: |sep-1| and |256-sep|
    logic [MAG_W-1:0] mag_l, mag_r;
    logic [MAG_W-1:0] sep_w, span_end;

    assign sep_w    = MAG_W'(item_reg.separation);
    assign span_end = MAG_W'(PAN_SPAN) + 1'b1;
    assign mag_l    = (sep_w == '0) ? MAG_W'(1) : sep_w - 1'b1;
    assign mag_r    = (sep_w <= span_end) ? span_end - sep_w : sep_w - span_end;

    logic [SQ_W-1:0] sq_l_reg, sq_r_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.classify)
        begin
            sq_l_reg <= SQ_W'(mag_l) * SQ_W'(mag_l);
            sq_r_reg <= SQ_W'(mag_r) * SQ_W'(mag_r);
        end
    end

    // (FULL_SCALE - d*d) * volume >> GAIN_SHIFT, clamped to 0 when negative
    logic [SQ_W-1:0]   diff_l, diff_r;
    logic [PROD_W-1:0] prod_l, prod_r;
    logic [GAIN_W-1:0] gain_l_reg, gain_r_reg;

    assign diff_l = (sq_l_reg > SQ_W'(FULL_SCALE)) ? '0 : SQ_W'(FULL_SCALE) - sq_l_reg;
    assign diff_r = (sq_r_reg > SQ_W'(FULL_SCALE)) ? '0 : SQ_W'(FULL_SCALE) - sq_r_reg;
    assign prod_l = PROD_W'(diff_l) * PROD_W'(item_reg.volume);
    assign prod_r = PROD_W'(diff_r) * PROD_W'(item_reg.volume);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            gain_l_reg <= prod_l[GAIN_SHIFT +: GAIN_W];
            gain_r_reg <= prod_r[GAIN_SHIFT +: GAIN_W];
        end
    end

    // response register
    vcap_rsp_t         rsp_reg;
    logic              rsp_valid_reg;
    logic [SLOT_W-1:0] slot_wide;

    assign slot_wide = SLOT_W'(slot_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.granted       <= granted_reg;
            rsp_reg.channel       <= granted_reg ? slot_wide[2:0] : 3'd0;
            rsp_reg.stop_previous <= granted_reg && stop_reg;
            rsp_reg.left_gain     <= granted_reg ? gain_l_reg : '0;
            rsp_reg.right_gain    <= granted_reg ? gain_r_reg : '0;
        end
    end

    assign rsp             = rsp_reg;
    assign rsp_valid       = rsp_valid_reg;
    assign status.out_free = !rsp_valid_reg || rsp_ready;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg >= PTR_FIRST && ptr_reg <= PTR_LAST)
        else $error("rotate pointer left shared range");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.granted |-> rsp.channel == 3'd0 && !rsp.stop_previous &&
        rsp.left_gain == '0 && rsp.right_gain == '0)
        else $error("refused beat carries nonzero fields");

    a_stop_pinned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.stop_previous |-> rsp.granted && rsp.channel < 3'd3)
        else $error("stop request on a shared channel");

endmodule

// ----- hw/rtl/voice_channel_allocator_with_pan_top.sv -----
// ============================================================================
// voice_channel_allocator_with_pan_top
// Mixer voice allocator: pinned ids, round-robin shared channels, stereo gain.
// ============================================================================
// Usage:
//   req channel (valid/ready): one beat per sound start request carrying
//   sound id, volume, separation and the mixer busy mask. rsp channel
//   (valid/ready): one beat per request with granted, channel,
//   stop_previous and the left/right pan gains. cfg port: single-cycle
//   writes of the six pinned ids by index; write only while idle.
//   Sequence: a pinned id goes from accept through classify, scale and
//   emit to rsp_valid. A shared id adds the probes of the round-robin scan,
//   1 to CHANNEL_COUNT-3 probes, between classify and scale. The sequencer
//   handles one request at a time; the next request is taken in the cycle
//   after the response is written into the output register, so a request
//   occupies the sequencer through the probe loop plus the square and
//   gain-multiply steps.
//   The response register decouples the sides: a new request is accepted
//   and processed while a response waits; only the final write stalls until
//   rsp_ready frees the register.
//   Reset: pinned ids return to their defaults, the rotate pointer returns
//   to channel 3, no response is pending.
// ============================================================================
module voice_channel_allocator_with_pan_top #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  vcap_pkg::vcap_req_t            req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output vcap_pkg::vcap_rsp_t            rsp,
    input  logic                           cfg_we,
    input  logic [vcap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vcap_pkg::CFG_W-1:0]     cfg_data
);
    import vcap_pkg::*;

    vcap_cmd_t    cmd;
    vcap_status_t status;

    // sequencer: owns state and probe count
    vcap_ctrl #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: config, pointer, gain math, response register
    vcap_datapath #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- tb/voice_channel_allocator_with_pan_top_tb.sv -----
// ============================================================================
// voice_channel_allocator_with_pan_top_tb
// Self-checking bench: pinned ids, round-robin shared channels, pan gains.
// ============================================================================
// Drives request beats through valid/ready with random gaps and output
// back-pressure. A scoreboard class mirrors the pinned id registers and the
// rotate pointer, predicts one response per accepted request, and compares
// the responses field by field in order. The pinned id registers are
// rewritten between phases while the block is idle.
// ============================================================================
module voice_channel_allocator_with_pan_top_tb;
    import vcap_pkg::*;

    localparam int CHANNEL_COUNT = 8;
    localparam int HOLD_CYCLES   = 300;
    // worst accept-to-response time, padded a little
    localparam int SETTLE_CYCLES = CHANNEL_COUNT + 4;

    // register write order; each entry is the index of that register
    localparam logic [CFG_IDX_W-1:0] ID_REGS [6] = '{CFG_SAW_UP_ID, CFG_SAW_IDLE_ID,
        CFG_SAW_FULL_ID, CFG_SAW_HIT_ID, CFG_STONE_MOVE_ID, CFG_PISTOL_ID};

    class voice_grant_ledger;
        logic [CFG_W-1:0] pinned_id [8];
        int               rr_ptr;
        vcap_rsp_t        pending_grants [$];
        int               errors;
        int               pinned_hits;
        int               shared_grants;
        int               refusals;

        function new();
            pinned_id[CFG_SAW_UP_ID]     = RST_SAW_UP_ID;
            pinned_id[CFG_SAW_IDLE_ID]   = RST_SAW_IDLE_ID;
            pinned_id[CFG_SAW_FULL_ID]   = RST_SAW_FULL_ID;
            pinned_id[CFG_SAW_HIT_ID]    = RST_SAW_HIT_ID;
            pinned_id[CFG_STONE_MOVE_ID] = RST_STONE_MOVE_ID;
            pinned_id[CFG_PISTOL_ID]     = RST_PISTOL_ID;
            rr_ptr = RESERVED_COUNT;
        endfunction

        // Negative products clamp to zero; otherwise keep the low 8 bits.
        function logic [GAIN_W-1:0] pan_gain(longint d, longint vol);
            longint p;
            p = (longint'(FULL_SCALE) - d * d) * vol;
            if (p < 0)
                return '0;
            return GAIN_W'(p >> GAIN_SHIFT);
        endfunction

        function vcap_rsp_t predict_grant(vcap_req_t r);
            vcap_rsp_t g;
            int        slot;
            bit        pinned;
            longint    d;
            slot   = -1;
            pinned = 1'b0;
            g      = '0;
            // later matches win: pistol over stone over the channel 0 ids
            if (r.sound_id == pinned_id[CFG_SAW_UP_ID]
                || r.sound_id == pinned_id[CFG_SAW_IDLE_ID]
                || r.sound_id == pinned_id[CFG_SAW_FULL_ID]
                || r.sound_id == pinned_id[CFG_SAW_HIT_ID])
                slot = 0;
            if (r.sound_id == pinned_id[CFG_STONE_MOVE_ID])
                slot = 1;
            if (r.sound_id == pinned_id[CFG_PISTOL_ID])
                slot = 2;
            if (slot >= 0)
                pinned = 1'b1;
            else
            begin
                for (int i = RESERVED_COUNT; i < CHANNEL_COUNT; i++)
                begin
                    rr_ptr++;
                    if (rr_ptr >= CHANNEL_COUNT)
                        rr_ptr = RESERVED_COUNT;
                    if (rr_ptr >= 8 || !r.busy_mask[rr_ptr])
                    begin
                        slot = rr_ptr;
                        break;
                    end
                end
            end
            if (slot < 0)
                return g;
            d = longint'(r.separation) - 1;
            g.granted       = 1'b1;
            g.channel       = 3'(slot);
            g.stop_previous = pinned;
            g.left_gain     = pan_gain(d, longint'(r.volume));
            g.right_gain    = pan_gain(longint'(PAN_SPAN) - d, longint'(r.volume));
            return g;
        endfunction

        function void note_request(vcap_req_t r);
            vcap_rsp_t g;
            g = predict_grant(r);
            if (!g.granted)
                refusals++;
            else if (g.stop_previous)
                pinned_hits++;
            else
                shared_grants++;
            pending_grants.push_back(g);
        endfunction

        function void check_response(vcap_rsp_t got);
            vcap_rsp_t exp_g;
            if (pending_grants.size() == 0)
            begin
                $error("response beat with no request outstanding: %h", got);
                errors++;
                return;
            end
            exp_g = pending_grants.pop_front();
            if (got.granted !== exp_g.granted)
            begin
                $error("granted: expected %0d, got %0d", exp_g.granted, got.granted);
                errors++;
            end
            if (got.channel !== exp_g.channel)
            begin
                $error("channel: expected %0d, got %0d", exp_g.channel, got.channel);
                errors++;
            end
            if (got.stop_previous !== exp_g.stop_previous)
            begin
                $error("stop_previous: expected %0d, got %0d", exp_g.stop_previous,
                       got.stop_previous);
                errors++;
            end
            if (got.left_gain !== exp_g.left_gain)
            begin
                $error("left_gain: expected %0d, got %0d", exp_g.left_gain,
                       got.left_gain);
                errors++;
            end
            if (got.right_gain !== exp_g.right_gain)
            begin
                $error("right_gain: expected %0d, got %0d", exp_g.right_gain,
                       got.right_gain);
                errors++;
            end
        endfunction

        function int pending();
            return pending_grants.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    vcap_req_t            req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    vcap_rsp_t            rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    voice_grant_ledger ledger = new();

    bit steady;        // no idling on either side while set
    bit hold_request;  // asks the receiver for one long hold-off
    int hold_left;
    int requests_sent;
    int id_settings;

    voice_channel_allocator_with_pan_top #(
        .CHANNEL_COUNT(CHANNEL_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #3_000_000;
        $display("voice_channel_allocator_with_pan_top verification failed");
        $finish;
    end

    // Both sides are sampled at the edge, before this edge's updates land,
    // so the order of processes within the step does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                ledger.check_response(rsp);
            if (req_valid && req_ready)
                ledger.note_request(req);
        end
    end

    // Receiver: ~10% random stalls, none while steady, plus one long
    // hold-off counted here so the block backs up onto its input.
    initial
    begin
        rsp_ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (steady)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    function automatic vcap_req_t make_req(logic [7:0] id, logic [3:0] vol,
                                           logic [8:0] sep, logic [7:0] busy);
        vcap_req_t r;
        r.sound_id   = id;
        r.volume     = vol;
        r.separation = sep;
        r.busy_mask  = busy;
        return r;
    endfunction

    // Roughly a third pinned ids, the rest shared; busy masks skewed so that
    // refusals and single-free-channel scans show up often.
    function automatic vcap_req_t random_request();
        vcap_req_t r;
        int        pick;
        int        k;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.sound_id = ledger.pinned_id[ID_REGS[$urandom_range(0, 5)]];
        else
            r.sound_id = 8'($urandom);
        r.volume = 4'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            r.separation = 9'($urandom_range(1, 256));
        else if (pick < 90)
            r.separation = '0;
        else
            r.separation = 9'($urandom_range(257, 511));
        pick = $urandom_range(0, 99);
        k    = $urandom_range(RESERVED_COUNT, 7);
        if (pick < 25)
            r.busy_mask = {5'h1f, 3'($urandom)};
        else if (pick < 50)
            r.busy_mask = {5'h1f, 3'($urandom)} & ~(8'h01 << k);
        else
            r.busy_mask = 8'($urandom);
        return r;
    endfunction

    // One request beat; valid stays up until the beat is taken.
    task automatic send_request(input vcap_req_t r);
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        requests_sent++;
    endtask

    // Stop offering and wait until every predicted response has come back,
    // then let the sequencer settle.
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic write_ids(input logic [CFG_W-1:0] ids [6]);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= ID_REGS[i];
            cfg_data  <= ids[i];
            ledger.pinned_id[ID_REGS[i]] = ids[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        id_settings++;
    endtask

    // New id setting, one request per pinned id (exercises the priority of
    // overlapping ids), then random traffic.
    task automatic run_phase(input logic [CFG_W-1:0] ids [6], input int count,
                             input bit no_idle, input bit hold, input bit mid_pause);
        drain();
        write_ids(ids);
        steady = no_idle;
        for (int i = 0; i < 6; i++)
            send_request(make_req(ids[i], 4'($urandom), 9'($urandom_range(1, 256)),
                                  8'($urandom)));
        if (hold)
            hold_request = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if (mid_pause && n == count / 2)
                drain();
            send_request(random_request());
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] ids [6];
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        req          <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        requests_sent = 0;
        id_settings   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset id values: every pinned id, four against a full busy mask,
        // volume and separation extremes, out-of-range separation both ways,
        // shared scans that wrap, find one free channel, or find none.
        send_request(make_req(RST_SAW_UP_ID,     4'd15, 9'd1,   8'hff));
        send_request(make_req(RST_SAW_IDLE_ID,   4'd0,  9'd256, 8'h00));
        send_request(make_req(RST_SAW_FULL_ID,   4'd15, 9'd128, 8'hff));
        send_request(make_req(RST_SAW_HIT_ID,    4'd8,  9'd0,   8'h00));
        send_request(make_req(RST_STONE_MOVE_ID, 4'd15, 9'd511, 8'hff));
        send_request(make_req(RST_PISTOL_ID,     4'd15, 9'd257, 8'hff));
        send_request(make_req(8'd0,   4'd15, 9'd256, 8'h00));
        send_request(make_req(8'd255, 4'd15, 9'd1,   8'hf8));
        send_request(make_req(8'd2,   4'd7,  9'd64,  8'hf7));
        send_request(make_req(8'd3,   4'd15, 9'd511, 8'h7f));
        send_request(make_req(8'd4,   4'd15, 9'd0,   8'hff));
        send_request(make_req(8'd5,   4'd15, 9'd200, 8'h07));
        send_request(make_req(8'd200, 4'd15, 9'd129, 8'he7));
        send_request(make_req(8'd100, 4'd1,  9'd2,   8'h00));
        send_request(make_req(8'd170, 4'd10, 9'd300, 8'h55));
        send_request(make_req(8'd85,  4'd5,  9'd170, 8'haa));

        // all ids zero: everything collides, pistol wins; no idling here
        ids = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        run_phase(ids, 100, 1'b1, 1'b0, 1'b0);
        // all ids 255, with the long receiver hold-off
        ids = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
        run_phase(ids, 100, 1'b0, 1'b1, 1'b0);
        // stone shares an id with channel 0, pistol with another
        ids = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd255, 8'd0};
        run_phase(ids, 100, 1'b0, 1'b0, 1'b0);
        // random settings; the first pauses midway until drained
        for (int i = 0; i < 6; i++)
            ids[i] = 8'($urandom);
        run_phase(ids, 150, 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++)
            ids[i] = 8'($urandom);
        run_phase(ids, 150, 1'b0, 1'b0, 1'b0);
        // back to the reset values
        ids = '{RST_SAW_UP_ID, RST_SAW_IDLE_ID, RST_SAW_FULL_ID, RST_SAW_HIT_ID,
                RST_STONE_MOVE_ID, RST_PISTOL_ID};
        run_phase(ids, 150, 1'b0, 1'b0, 1'b0);

        drain();
        if (ledger.pending() != 0)
        begin
            $error("%0d responses never arrived", ledger.pending());
            ledger.errors++;
        end
        $display("Ran %0d requests across %0d pinned id settings plus reset values.",
                 requests_sent, id_settings);
        $display("Pinned grants %0d, shared grants %0d, refused %0d.",
                 ledger.pinned_hits, ledger.shared_grants, ledger.refusals);
        if (ledger.errors == 0)
            $display("voice_channel_allocator_with_pan_top verification clean");
        else
            $display("voice_channel_allocator_with_pan_top verification failed");
        $finish;
    end

endmodule
